// ===== rtl/euclidean_distance_isqrt_defines.svh =====
// ----------------------------------------------------------------------------
// Euclidean distance assertion macros
// Shared macros for the concurrent assertions of the distance block.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_ISQRT_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_ISQRT_DEFINES_SVH

// Implication in the same cycle, checked only outside reset.
`define EDI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("distance block assertion failed");

// Implication into the next cycle, checked at every edge.
`define EDI_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("distance block assertion failed");

`endif

// ===== rtl/edi_pkg.sv =====
// ----------------------------------------------------------------------------
// Euclidean distance package
// Widths and constants shared by the distance block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package edi_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int DIST_W  = 15;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Front stages (difference, magnitude, square, sum), root stages, output.
    localparam int PIPE_DEPTH = 4 + ROOT_W + 1;

endpackage

`default_nettype wire

// ===== rtl/euclidean_distance_isqrt.sv =====
// ----------------------------------------------------------------------------
// Euclidean distance with integer square root
// Floor of the distance between two signed 16-bit points, saturated to 15 bits.
// ----------------------------------------------------------------------------
// An input word holds two points. It is taken at a rising edge where start is
// high and busy is low; busy is always low, so a new word can enter in every
// cycle. The result word appears on o_distance and o_saturated for exactly one
// cycle, marked by o_done, which is registered like the result.
// The pipeline forms the coordinate differences, their magnitudes, the squares
// and their 33-bit sum in four stages. The floor root follows in 17 stages,
// one result bit per stage, and a last stage clamps the root to 32767.
// Throughput is one word per cycle; the root stages set the depth.
// A synchronous reset clears every valid bit, so words in flight are dropped
// and no result appears until new words arrive. The receiver has no way to
// stall the block and must take each result in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_distance_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [edi_pkg::COORD_W-1:0] i_first_x,
    input  wire logic [edi_pkg::COORD_W-1:0] i_first_y,
    input  wire logic [edi_pkg::COORD_W-1:0] i_second_x,
    input  wire logic [edi_pkg::COORD_W-1:0] i_second_y,
    output logic                             o_done,
    output logic [edi_pkg::DIST_W-1:0]       o_distance,
    output logic                             o_saturated
);

    logic                          r_dif_vld;
    logic [edi_pkg::DIFF_W-1:0]    r_dx;
    logic [edi_pkg::DIFF_W-1:0]    r_dy;
    logic [edi_pkg::DIFF_W-1:0]    n_dx;
    logic [edi_pkg::DIFF_W-1:0]    n_dy;

    logic                          r_mag_vld;
    logic [edi_pkg::MAG_W-1:0]     r_ax;
    logic [edi_pkg::MAG_W-1:0]     r_ay;
    logic [edi_pkg::MAG_W-1:0]     n_negx;
    logic [edi_pkg::MAG_W-1:0]     n_negy;
    logic [edi_pkg::MAG_W-1:0]     n_ax;
    logic [edi_pkg::MAG_W-1:0]     n_ay;

    logic                          r_sq_vld;
    logic [edi_pkg::SQ_W-1:0]      r_sqx;
    logic [edi_pkg::SQ_W-1:0]      r_sqy;

    logic                          r_vld [0:edi_pkg::ROOT_W];
    logic [edi_pkg::REM_W-1:0]     r_rem [0:edi_pkg::ROOT_W];
    logic [edi_pkg::ROOT_W-1:0]    r_q   [0:edi_pkg::ROOT_W];
    logic [edi_pkg::RAD_W-1:0]     r_rad [0:edi_pkg::ROOT_W];

    logic                          r_done;
    logic [edi_pkg::DIST_W-1:0]    r_distance;
    logic                          r_saturated;
    logic                          n_sat;

    assign busy = 1'b0;

    always_comb begin
        n_dx   = {i_second_x[edi_pkg::COORD_W-1], i_second_x}
               - {i_first_x[edi_pkg::COORD_W-1], i_first_x};
        n_dy   = {i_second_y[edi_pkg::COORD_W-1], i_second_y}
               - {i_first_y[edi_pkg::COORD_W-1], i_first_y};
        n_negx = {edi_pkg::MAG_W{1'b0}} - r_dx[edi_pkg::MAG_W-1:0];
        n_negy = {edi_pkg::MAG_W{1'b0}} - r_dy[edi_pkg::MAG_W-1:0];
        n_ax   = r_dx[edi_pkg::DIFF_W-1] ? n_negx
                                         : r_dx[edi_pkg::MAG_W-1:0];
        n_ay   = r_dy[edi_pkg::DIFF_W-1] ? n_negy
                                         : r_dy[edi_pkg::MAG_W-1:0];
        n_sat  = |r_q[edi_pkg::ROOT_W][edi_pkg::ROOT_W-1:edi_pkg::DIST_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dif_vld <= 1'b0;
            r_mag_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_vld[0]  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_dif_vld <= start;
            r_mag_vld <= r_dif_vld;
            r_sq_vld  <= r_mag_vld;
            r_vld[0]  <= r_sq_vld;
            r_done    <= r_vld[edi_pkg::ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_ax        <= n_ax;
        r_ay        <= n_ay;
        r_sqx       <= r_ax * r_ax;
        r_sqy       <= r_ay * r_ay;
        r_rem[0]    <= {edi_pkg::REM_W{1'b0}};
        r_q[0]      <= {edi_pkg::ROOT_W{1'b0}};
        r_rad[0]    <= edi_pkg::RAD_W'({1'b0, r_sqx} + {1'b0, r_sqy});
        r_saturated <= n_sat;
        r_distance  <= n_sat ? edi_pkg::DIST_MAX
                             : r_q[edi_pkg::ROOT_W][edi_pkg::DIST_W-1:0];
    end

    for (genvar k = 0; k < edi_pkg::ROOT_W; k++) begin : g_root
        logic [edi_pkg::REM_W-1:0]  n_shift;
        logic [edi_pkg::REM_W-1:0]  n_trial;
        logic [edi_pkg::REM_W-1:0]  n_rem;
        logic [edi_pkg::ROOT_W-1:0] n_q;

        always_comb begin
            n_shift = {r_rem[k][edi_pkg::REM_W-3:0],
                       r_rad[k][edi_pkg::RAD_W-1 -: 2]};
            n_trial = {1'b0, r_q[k], 2'b01};
            if (n_shift >= n_trial) begin
                n_rem = n_shift - n_trial;
                n_q   = {r_q[k][edi_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem = n_shift;
                n_q   = {r_q[k][edi_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_q[k+1]   <= n_q;
            r_rad[k+1] <= {r_rad[k][edi_pkg::RAD_W-3:0], 2'b00};
        end
    end

    assign o_done      = r_done;
    assign o_distance  = r_distance;
    assign o_saturated = r_saturated;

endmodule

`default_nettype wire

// ===== rtl/edi_checker.sv =====
// ----------------------------------------------------------------------------
// Euclidean distance port checker
// Port-level assertions on the distance block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euclidean_distance_isqrt_defines.svh"

module edi_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic [edi_pkg::COORD_W-1:0] i_first_x,
    input wire logic [edi_pkg::COORD_W-1:0] i_first_y,
    input wire logic [edi_pkg::COORD_W-1:0] i_second_x,
    input wire logic [edi_pkg::COORD_W-1:0] i_second_y,
    input wire logic                        o_done,
    input wire logic [edi_pkg::DIST_W-1:0]  o_distance,
    input wire logic                        o_saturated
);

    logic same_pt;

    assign same_pt = start && (i_first_x == i_second_x) && (i_first_y == i_second_y);

    // A result word only ever follows an accepted input word by the fixed latency.
    `EDI_ASSERT_IMP(a_done_follows_start, i_clk, i_rst_n, o_done, $past(start && !busy, edi_pkg::PIPE_DEPTH))
    // A clamped result shows the largest distance.
    `EDI_ASSERT_IMP(a_sat_is_max, i_clk, i_rst_n, o_done && o_saturated, o_distance == edi_pkg::DIST_MAX)
    // Two equal points give a zero distance without saturation.
    `EDI_ASSERT_IMP(a_same_point_zero, i_clk, i_rst_n, o_done && $past(same_pt, edi_pkg::PIPE_DEPTH), o_distance == '0 && !o_saturated)
    // Reset drops every word in flight.
    `EDI_ASSERT_NXT(a_reset_clears, i_clk, !i_rst_n, !o_done)

endmodule

bind euclidean_distance_isqrt edi_checker u_edi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_first_x   (i_first_x),
    .i_first_y   (i_first_y),
    .i_second_x  (i_second_x),
    .i_second_y  (i_second_y),
    .o_done      (o_done),
    .o_distance  (o_distance),
    .o_saturated (o_saturated)
);

`default_nettype wire

// ===== test/euclidean_distance_isqrt_tb.sv =====
// ----------------------------------------------------------------------------
// Euclidean distance block testbench
// Drives point pairs through the command handshake, predicts the saturated
// floor distance of each pair and checks every result word in order.
// ----------------------------------------------------------------------------
module euclidean_distance_isqrt_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import edi_pkg::*;

    localparam int RAND_PAIRS  = 1700;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        int                 gap;
        bit                 drain;
    } point_pair_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } dist_word_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [COORD_W-1:0] i_first_x = '0;
    logic [COORD_W-1:0] i_first_y = '0;
    logic [COORD_W-1:0] i_second_x = '0;
    logic [COORD_W-1:0] i_second_y = '0;
    logic               o_done;
    logic [DIST_W-1:0]  o_distance;
    logic               o_saturated;

    point_pair_t pair_q[$];
    dist_word_t  dist_q[$];
    int          idle_cnt = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    euclidean_distance_isqrt DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .o_done      (o_done),
        .o_distance  (o_distance),
        .o_saturated (o_saturated)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic dist_word_t calc_distance(input logic [COORD_W-1:0] fx,
                                                 input logic [COORD_W-1:0] fy,
                                                 input logic [COORD_W-1:0] sx,
                                                 input logic [COORD_W-1:0] sy);
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        bit [63:0]               ax;
        bit [63:0]               ay;
        bit [63:0]               sum;
        bit [63:0]               root;
        bit [63:0]               trial;
        dist_word_t              w;
        dx = $signed({sx[COORD_W-1], sx}) - $signed({fx[COORD_W-1], fx});
        dy = $signed({sy[COORD_W-1], sy}) - $signed({fy[COORD_W-1], fy});
        ax = dx[COORD_W] ? 64'(-dx) : 64'(dx);
        ay = dy[COORD_W] ? 64'(-dy) : 64'(dy);
        ax = ax & 64'h1FFFF;
        ay = ay & 64'h1FFFF;
        sum = ax * ax + ay * ay;
        root = '0;
        for (int b = COORD_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum) begin
                root = trial;
            end
        end
        if (root > 64'(DIST_MAX)) begin
            w.distance  = DIST_MAX;
            w.saturated = 1'b1;
        end else begin
            w.distance  = root[DIST_W-1:0];
            w.saturated = 1'b0;
        end
        return w;
    endfunction

    function automatic int rand_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return v;
    endfunction

    function automatic int fit_coord(input int v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    task automatic add_pair(input int fx, input int fy, input int sx, input int sy,
                            input int gap, input bit drain);
        point_pair_t p;
        p.first_x  = fx[COORD_W-1:0];
        p.first_y  = fy[COORD_W-1:0];
        p.second_x = sx[COORD_W-1:0];
        p.second_y = sy[COORD_W-1:0];
        p.gap      = gap;
        p.drain    = drain;
        pair_q.push_back(p);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        logic        nxt_start;
        point_pair_t head;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_cnt = 0;
        end else begin
            nxt_start = start;
            if (start && !busy) begin
                dist_q.push_back(calc_distance(i_first_x, i_first_y, i_second_x, i_second_y));
                nxt_start = 1'b0;
            end
            if (!nxt_start && pair_q.size() != 0) begin
                head = pair_q[0];
                if (idle_cnt < head.gap) begin
                    idle_cnt++;
                end else if (!(head.drain && dist_q.size() != 0)) begin
                    void'(pair_q.pop_front());
                    i_first_x  <= head.first_x;
                    i_first_y  <= head.first_y;
                    i_second_x <= head.second_x;
                    i_second_y <= head.second_y;
                    nxt_start = 1'b1;
                    idle_cnt = 0;
                end
            end
            start <= nxt_start;
        end
    end

    always @(posedge i_clk) begin
        dist_word_t want;
        if (i_rst_n && o_done) begin
            if (dist_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word: distance %0d saturated %0b",
                                          o_distance, o_saturated));
            end else begin
                want = dist_q.pop_front();
                if (o_distance !== want.distance) begin
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              o_distance, want.distance));
                end
                if (o_saturated !== want.saturated) begin
                    report_mismatch($sformatf("saturated %0b, expected %0b",
                                              o_saturated, want.saturated));
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int  c[4];
        int  d;
        int  e;
        int  gap;
        bit  calm;
        bit  drain;
        add_pair(0, 0, 0, 0, $urandom_range(0, 11), 1'b0);
        add_pair(-32768, -32768, -32768, -32768, $urandom_range(0, 11), 1'b0);
        add_pair(32767, 32767, 32767, 32767, $urandom_range(0, 11), 1'b0);
        add_pair(-32768, -32768, 32767, 32767, $urandom_range(0, 11), 1'b0);
        add_pair(32767, 32767, -32768, -32768, $urandom_range(0, 11), 1'b0);
        add_pair(-32768, 0, 32767, 0, $urandom_range(0, 11), 1'b0);
        add_pair(0, -32768, 0, 32767, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, 32767, 0, $urandom_range(0, 11), 1'b0);
        add_pair(-32768, 0, 0, 0, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, 32767, 1, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, 32767, 256, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, 0, -32767, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, 3, 4, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, -3, -4, $urandom_range(0, 11), 1'b0);
        add_pair(1, 1, 4, 5, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, 1, 1, $urandom_range(0, 11), 1'b0);
        add_pair(0, 0, 2, 1, $urandom_range(0, 11), 1'b0);
        add_pair(-1, -1, 0, 0, $urandom_range(0, 11), 1'b0);
        add_pair(-21846, 21845, 21845, -21846, $urandom_range(0, 11), 1'b0);
        add_pair(21845, -21846, -21846, 21845, 0, 1'b0);
        add_pair(-32768, 32767, 32767, -32768, 0, 1'b0);
        calm = 1'b0;
        for (int n = 0; n < RAND_PAIRS; n++) begin
            if (n % 50 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            gap = calm ? 0 : $urandom_range(0, 11);
            drain = (n % 400 == 0);
            case ($urandom_range(0, 7))
                5, 6: begin
                    c[0] = rand_coord();
                    c[1] = rand_coord();
                    c[2] = fit_coord(c[0] + $urandom_range(0, 600) - 300);
                    c[3] = fit_coord(c[1] + $urandom_range(0, 600) - 300);
                end
                7: begin
                    d = 32700 + $urandom_range(0, 140);
                    e = $urandom_range(0, 300);
                    c[0] = -16400 + $urandom_range(0, 30);
                    c[2] = c[0] + d;
                    c[1] = $urandom_range(0, 1000) - 500;
                    c[3] = c[1] + e;
                    if ($urandom_range(0, 1)) begin
                        c = '{c[2], c[3], c[0], c[1]};
                    end
                    if ($urandom_range(0, 1)) begin
                        c = '{c[1], c[0], c[3], c[2]};
                    end
                end
                default: begin
                    c[0] = rand_coord();
                    c[1] = rand_coord();
                    c[2] = rand_coord();
                    c[3] = rand_coord();
                end
            endcase
            add_pair(c[0], c[1], c[2], c[3], gap, drain);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pair_q.size() != 0 || start) @(posedge i_clk);
        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (mismatch_cnt == 0 && dist_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
